// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the event rate filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ERAFL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that a condition never holds.
`define ERAFL_ASSERT_NEVER(label, cond, msg) \
	`ERAFL_ASSERT(label, !(cond), msg)

`endif

// File: hw/rtl/erafl_pkg.sv
// Package with the types, codes and constants of the event rate filter.
package erafl_pkg;

	localparam int SLOT_COUNT_DEF = 16;

	localparam int ID_W      = 16;
	localparam int TIME_W    = 32;
	localparam int CNT_W     = 16;
	localparam int PHASE_W   = 8;
	localparam int VERDICT_W = 3;
	localparam int SAMPLE_W  = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CNT_W-1:0]    WINDOW_RESET    = CNT_W'(1000);
	localparam logic [CNT_W-1:0]    THRESHOLD_RESET = CNT_W'(10);
	localparam logic [SAMPLE_W-1:0] SAMPLE_RESET    = SAMPLE_W'(8);

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_MS       = 2'd0,
		REG_ADMIT_THRESHOLD = 2'd1,
		REG_SAMPLE_EVERY    = 2'd2
	} cfg_reg_t;

	localparam logic [VERDICT_W-1:0] V_UNDER      = 3'd0;
	localparam logic [VERDICT_W-1:0] V_SAMPLED    = 3'd1;
	localparam logic [VERDICT_W-1:0] V_SUPPRESSED = 3'd2;
	localparam logic [VERDICT_W-1:0] V_FULL       = 3'd3;
	localparam logic [VERDICT_W-1:0] V_BYPASS     = 3'd4;
	localparam logic [VERDICT_W-1:0] V_RESERVED   = 3'd5;

	typedef struct packed {
		logic [TIME_W-1:0]  start;
		logic [CNT_W-1:0]   count;
		logic [CNT_W-1:0]   drop;
		logic [PHASE_W-1:0] phase;
	} slot_entry_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic out_stall;
	} dp_stat_t;

endpackage

// File: hw/rtl/erafl_if.sv
// Valid/ready channel interfaces for event words and result words.
interface erafl_event_if;
	import erafl_pkg::*;
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   event_id;
	logic [TIME_W-1:0] now_ms;
	logic              bypass;
	modport source (output valid, event_id, now_ms, bypass, input ready);
	modport sink (input valid, event_id, now_ms, bypass, output ready);
endinterface

interface erafl_result_if;
	import erafl_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 admit;
	logic [VERDICT_W-1:0] verdict;
	logic [CNT_W-1:0]     window_count;
	logic [CNT_W-1:0]     dropped_count;
	modport source (output valid, admit, verdict, window_count, dropped_count, input ready);
	modport sink (input valid, admit, verdict, window_count, dropped_count, output ready);
endinterface

// File: hw/rtl/erafl_datapath.sv
// Datapath: configuration registers, slot keys, slot memory, update logic and result register.
module erafl_datapath #(
	parameter int SLOT_COUNT = erafl_pkg::SLOT_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  erafl_pkg::dp_cmd_t                  cmd,
	output erafl_pkg::dp_stat_t                 stat,
	input  logic [erafl_pkg::ID_W-1:0]          evt_event_id,
	input  logic [erafl_pkg::TIME_W-1:0]        evt_now_ms,
	input  logic                                evt_bypass,
	input  logic                                cfg_we,
	input  logic [erafl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [erafl_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic                                res_admit,
	output logic [erafl_pkg::VERDICT_W-1:0]     res_verdict,
	output logic [erafl_pkg::CNT_W-1:0]         res_window_count,
	output logic [erafl_pkg::CNT_W-1:0]         res_dropped_count
);
	import erafl_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [CNT_W-1:0]    window_q;
	logic [CNT_W-1:0]    threshold_q;
	logic [SAMPLE_W-1:0] sample_q;

	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;
	logic              bypass_q;

	logic [ID_W-1:0] key_q [SLOT_COUNT];
	slot_entry_t     mem_q [SLOT_COUNT];

	logic             match_found;
	logic             free_found;
	logic [IDX_W-1:0] match_idx;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] rd_idx;

	logic             hit_q;
	logic             avail_q;
	logic [IDX_W-1:0] idx_q;
	slot_entry_t      rd_q;

	slot_entry_t        base;
	logic [TIME_W-1:0]  elapsed;
	logic               restart;
	logic [CNT_W-1:0]   cnt0;
	logic [CNT_W-1:0]   drop0;
	logic [PHASE_W-1:0] phase0;
	logic [CNT_W-1:0]   cnt1;
	logic [CNT_W-1:0]   drop1;
	logic [PHASE_W:0]   phase_inc;
	logic               under;
	logic               sampled;
	slot_entry_t        wr_entry;
	logic               do_write;

	logic                 res_valid_q;
	logic                 res_admit_q;
	logic [VERDICT_W-1:0] res_verdict_q;
	logic [CNT_W-1:0]     res_wc_q;
	logic [CNT_W-1:0]     res_dc_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			threshold_q <= THRESHOLD_RESET;
			sample_q    <= SAMPLE_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_MS:       window_q    <= cfg_data;
				REG_ADMIT_THRESHOLD: threshold_q <= cfg_data;
				REG_SAMPLE_EVERY:    sample_q    <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q     <= evt_event_id;
			now_q    <= evt_now_ms;
			bypass_q <= evt_bypass;
		end
	end

	// Parallel key compare; the lowest matching and the lowest free slot win.
	always_comb begin
		match_found = 1'b0;
		free_found  = 1'b0;
		match_idx   = '0;
		free_idx    = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (key_q[i] == id_q) begin
				match_found = 1'b1;
				match_idx   = IDX_W'(i);
			end
			if (key_q[i] == '0) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign rd_idx = match_found ? match_idx : free_idx;

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_q   <= match_found;
			avail_q <= match_found | free_found;
			idx_q   <= rd_idx;
			rd_q    <= mem_q[rd_idx];
		end
	end

	// Slot update. A freshly claimed slot starts from now with cleared counters.
	always_comb begin
		if (hit_q) begin
			base = rd_q;
		end else begin
			base       = '0;
			base.start = now_q;
		end
		elapsed   = now_q - base.start;
		restart   = elapsed > {{(TIME_W - CNT_W){1'b0}}, window_q};
		cnt0      = restart ? '0 : base.count;
		drop0     = restart ? '0 : base.drop;
		phase0    = restart ? '0 : base.phase;
		cnt1      = (cnt0 == CNT_MAX) ? cnt0 : cnt0 + CNT_W'(1);
		drop1     = (drop0 == CNT_MAX) ? drop0 : drop0 + CNT_W'(1);
		phase_inc = {1'b0, phase0} + (PHASE_W + 1)'(1);
		under     = cnt1 <= threshold_q;
		sampled   = phase_inc >= {1'b0, sample_q};

		wr_entry.start = restart ? now_q : base.start;
		wr_entry.count = cnt1;
		if (under) begin
			wr_entry.drop  = drop0;
			wr_entry.phase = phase0;
		end else begin
			wr_entry.drop  = drop1;
			wr_entry.phase = sampled ? '0 : phase_inc[PHASE_W-1:0];
		end
		do_write = cmd.commit && !bypass_q && (id_q != '0) && avail_q;
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_q[idx_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				key_q[i] <= '0;
			end
		end else if (do_write && !hit_q) begin
			key_q[idx_q] <= id_q;
		end
	end

	// Result register; it holds a word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (bypass_q) begin
				res_admit_q   <= 1'b1;
				res_verdict_q <= V_BYPASS;
				res_wc_q      <= '0;
				res_dc_q      <= '0;
			end else if (id_q == '0) begin
				res_admit_q   <= 1'b1;
				res_verdict_q <= V_RESERVED;
				res_wc_q      <= '0;
				res_dc_q      <= '0;
			end else if (!avail_q) begin
				res_admit_q   <= 1'b1;
				res_verdict_q <= V_FULL;
				res_wc_q      <= '0;
				res_dc_q      <= '0;
			end else begin
				res_admit_q   <= under | sampled;
				res_verdict_q <= under ? V_UNDER : (sampled ? V_SAMPLED : V_SUPPRESSED);
				res_wc_q      <= wr_entry.count;
				res_dc_q      <= wr_entry.drop;
			end
		end
	end

	assign stat.out_stall      = res_valid_q && !res_ready;
	assign res_valid           = res_valid_q;
	assign res_admit           = res_admit_q;
	assign res_verdict         = res_verdict_q;
	assign res_window_count    = res_wc_q;
	assign res_dropped_count   = res_dc_q;

endmodule

// File: hw/rtl/erafl_ctrl.sv
// Controller state machine: accept, key lookup, slot update and result commit.
module erafl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evt_valid,
	output logic                evt_ready,
	output erafl_pkg::dp_cmd_t  cmd,
	input  erafl_pkg::dp_stat_t stat
);
	import erafl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign evt_ready   = (state_q == ST_IDLE);
	assign cmd.capture = evt_valid && evt_ready;
	assign cmd.lookup  = (state_q == ST_LOOKUP);
	assign cmd.commit  = (state_q == ST_UPDATE) && !stat.out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (cmd.commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/event_rate_aggregation_filter_core.sv
// Top level of the per-id fixed-window event rate filter with sampling.
//
//   channel  direction  word contents                                  handshake
//   evt      in         event_id, now_ms, bypass                       valid/ready
//   res      out        admit, verdict, window_count, dropped_count    valid/ready
//   cfg      in         cfg_index, cfg_data                            cfg_we only
//
// Each event word passes three steps: one to accept it, one for the parallel key
// compare together with the read of the slot memory, and one to update the slot and
// load the result register. The slot memory is read and then written for the same
// slot, so a new word is accepted only once the current word has been committed.
// Reset clears the slot keys at once and loads the register defaults; no clearing
// pass is needed. A stalled result holds the update step until the result register
// frees, while an earlier result waiting there never blocks accepting the next word.
module event_rate_aggregation_filter_core #(
	parameter int SLOT_COUNT = erafl_pkg::SLOT_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	erafl_event_if.sink                      evt,
	erafl_result_if.source                   res,
	input  logic                             cfg_we,
	input  logic [erafl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [erafl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import erafl_pkg::*;

	// Command and status between the controller and the datapath.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	erafl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// The datapath owns the slot table, the configuration and the result register.
	erafl_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.evt_event_id      (evt.event_id),
		.evt_now_ms        (evt.now_ms),
		.evt_bypass        (evt.bypass),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.res_valid         (res.valid),
		.res_ready         (res.ready),
		.res_admit         (res.admit),
		.res_verdict       (res.verdict),
		.res_window_count  (res.window_count),
		.res_dropped_count (res.dropped_count)
	);

endmodule

// File: hw/rtl/erafl_checker.sv
// Port-level checker for the event rate filter and its bind to the top level.
`include "assert_macros.svh"

module erafl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             evt_valid,
	input logic                             evt_ready,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic [erafl_pkg::VERDICT_W-1:0]  res_verdict
);
	import erafl_pkg::*;

	// A pending result word stays offered.
	`ERAFL_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result word withdrawn")

	// A stalled result word keeps its verdict.
	`ERAFL_ASSERT(a_res_stable, res_valid && !res_ready |=> $stable(res_verdict), "result word changed while stalled")

	// Only one event word is in work at a time.
	`ERAFL_ASSERT(a_one_in_work, evt_valid && evt_ready |=> !evt_ready, "second event word taken during work")

	// A new result word only appears from the update step, never while idle.
	`ERAFL_ASSERT_NEVER(a_res_from_idle, $rose(res_valid) && $past(evt_ready), "result word appeared without work")

endmodule

bind event_rate_aggregation_filter_core erafl_checker u_erafl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.evt_valid   (evt.valid),
	.evt_ready   (evt.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_verdict (res.verdict)
);

// File: test/tb_top.sv
// Self-checking testbench for the per-id fixed-window event rate filter with sampling.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import erafl_pkg::*;

	// A register index that the block does not implement. Writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

	// One result word as the block reports it.
	typedef struct packed {
		logic                 admit;
		logic [VERDICT_W-1:0] verdict;
		logic [CNT_W-1:0]     window_count;
		logic [CNT_W-1:0]     dropped_count;
	} verdict_word_t;

	// Tracks the admission decisions of the filter. It keeps its own copy of the slot
	// table and of the three registers, works out the verdict of every accepted event
	// word, and compares the result words against those verdicts in order.
	class admission_tracker;
		logic [CNT_W-1:0]    window_len;
		logic [CNT_W-1:0]    free_quota;
		logic [SAMPLE_W-1:0] sample_div;
		logic [ID_W-1:0]     slot_id [SLOT_COUNT_DEF];
		slot_entry_t         slot [SLOT_COUNT_DEF];
		verdict_word_t       pending_verdicts [$];
		int                  errors;

		function new();
			window_len = WINDOW_RESET;
			free_quota = THRESHOLD_RESET;
			sample_div = SAMPLE_RESET;
			foreach (slot_id[i]) begin
				slot_id[i] = '0;
			end
			errors = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_WINDOW_MS: begin
					window_len = data;
				end
				REG_ADMIT_THRESHOLD: begin
					free_quota = data;
				end
				REG_SAMPLE_EVERY: begin
					sample_div = data[SAMPLE_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void push_word(logic adm, logic [VERDICT_W-1:0] vd, logic [CNT_W-1:0] wc,
				logic [CNT_W-1:0] dc);
			verdict_word_t w;
			w.admit = adm;
			w.verdict = vd;
			w.window_count = wc;
			w.dropped_count = dc;
			pending_verdicts.push_back(w);
		endfunction

		function void note_event(logic [ID_W-1:0] id, logic [TIME_W-1:0] stamp, logic byp);
			int s;
			int vacant;
			logic [TIME_W-1:0] elapsed;
			logic [PHASE_W:0] next_phase;
			s = -1;
			vacant = -1;
			if (byp) begin
				push_word(1'b1, V_BYPASS, '0, '0);
				return;
			end
			if (id == '0) begin
				push_word(1'b1, V_RESERVED, '0, '0);
				return;
			end
			for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
				if (slot_id[i] == id) begin
					s = i;
					break;
				end
				if (vacant < 0 && slot_id[i] == '0) begin
					vacant = i;
				end
			end
			if (s < 0) begin
				if (vacant < 0) begin
					push_word(1'b1, V_FULL, '0, '0);
					return;
				end
				s = vacant;
				slot_id[s] = id;
				slot[s].start = stamp;
				slot[s].count = '0;
				slot[s].drop = '0;
				slot[s].phase = '0;
			end
			elapsed = stamp - slot[s].start;
			if (elapsed > {{(TIME_W-CNT_W){1'b0}}, window_len}) begin
				slot[s].start = stamp;
				slot[s].count = '0;
				slot[s].drop = '0;
				slot[s].phase = '0;
			end
			if (slot[s].count != CNT_MAX) begin
				slot[s].count = slot[s].count + 1'b1;
			end
			if (slot[s].count <= free_quota) begin
				push_word(1'b1, V_UNDER, slot[s].count, slot[s].drop);
				return;
			end
			if (slot[s].drop != CNT_MAX) begin
				slot[s].drop = slot[s].drop + 1'b1;
			end
			next_phase = {1'b0, slot[s].phase} + 1'b1;
			if (next_phase >= {1'b0, sample_div}) begin
				slot[s].phase = '0;
				push_word(1'b1, V_SAMPLED, slot[s].count, slot[s].drop);
			end else begin
				slot[s].phase = next_phase[PHASE_W-1:0];
				push_word(1'b0, V_SUPPRESSED, slot[s].count, slot[s].drop);
			end
		endfunction

		function void check_verdict(verdict_word_t got);
			verdict_word_t want;
			if (pending_verdicts.size() == 0) begin
				$error("result word with no event waiting: admit %0d verdict %0d",
					got.admit, got.verdict);
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.admit !== want.admit) begin
				$error("admit: expected %0d, got %0d", want.admit, got.admit);
				errors++;
			end
			if (got.verdict !== want.verdict) begin
				$error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
				errors++;
			end
			if (got.window_count !== want.window_count) begin
				$error("window_count: expected %0d, got %0d", want.window_count,
					got.window_count);
				errors++;
			end
			if (got.dropped_count !== want.dropped_count) begin
				$error("dropped_count: expected %0d, got %0d", want.dropped_count,
					got.dropped_count);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_verdicts.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	erafl_event_if  evt ();
	erafl_result_if res ();

	event_rate_aggregation_filter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	admission_tracker tracker = new();

	// Percentages of cycles in which the event sender and the result receiver idle.
	int send_idle_pct;
	int recv_idle_pct;

	// While set, the receiver refuses every result word. Driven by a cycle counter of
	// its own so that the sender keeps offering words and the block backs up.
	logic result_hold;

	// Sixteen event ids that fill the slot table. The first two sit at the id extremes;
	// the others are random, distinct and nonzero. Any other nonzero id finds the table
	// full once the directed part has run.
	logic [ID_W-1:0] known_ids [16];

	// Running millisecond clock for the random events. It starts close to the top of
	// the 32-bit range so that the wrap is crossed during the run.
	logic [TIME_W-1:0] stamp_clock;

	always #5 clk = ~clk;

	// Receiver: ready is changed only at the falling edge.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			res.ready <= !result_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every result word accepted at a rising edge is checked against the oldest verdict.
	always @(posedge clk) begin
		verdict_word_t got;
		if (arst_n && res.valid && res.ready) begin
			got.admit = res.admit;
			got.verdict = res.verdict;
			got.window_count = res.window_count;
			got.dropped_count = res.dropped_count;
			tracker.check_verdict(got);
		end
	end

	// Offers one event word and returns at the falling edge after its handshake. Valid
	// is left high so that a following word can go out back to back; the caller lowers
	// it when it stops sending.
	task automatic send_event(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] stamp,
			input logic byp);
		while ($urandom_range(99) < send_idle_pct) begin
			evt.valid <= 1'b0;
			@(negedge clk);
		end
		evt.valid <= 1'b1;
		evt.event_id <= id;
		evt.now_ms <= stamp;
		evt.bypass <= byp;
		do begin
			@(posedge clk);
		end while (!evt.ready);
		tracker.note_event(id, stamp, byp);
		@(negedge clk);
	endtask

	// Stops sending and waits until every verdict has come back, then idles on for
	// the three-step pipeline to empty.
	task automatic drain_results();
		evt.valid <= 1'b0;
		while (tracker.outstanding() != 0) begin
			@(negedge clk);
		end
		repeat (5) @(negedge clk);
	endtask

	// One register write. The write enable is left high; apply_settings lowers it after
	// the last write of a batch.
	task automatic config_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.set_register(idx, data);
		@(negedge clk);
	endtask

	// Writes all three registers and the spare index. The sample register gets random
	// upper bits, which the block must drop.
	task automatic apply_settings(input logic [CNT_W-1:0] win, input logic [CNT_W-1:0] thr,
			input logic [SAMPLE_W-1:0] smp);
		logic [CFG_DATA_W-SAMPLE_W-1:0] junk;
		junk = (CFG_DATA_W-SAMPLE_W)'($urandom_range(255));
		config_write(REG_WINDOW_MS, win);
		config_write(REG_ADMIT_THRESHOLD, thr);
		config_write(REG_SAMPLE_EVERY, {junk, smp});
		config_write(CFG_IDX_SPARE, CFG_DATA_W'($urandom_range(65535)));
		cfg_we <= 1'b0;
	endtask

	function automatic bit id_taken(input logic [ID_W-1:0] cand, input int n);
		for (int i = 0; i < n; i++) begin
			if (known_ids[i] == cand) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// One random event word. Most words carry a known id at the running clock, which is
	// what drives windows, thresholds and sampling. The rest are bypassed words with any
	// id and time, reserved-id words, and unknown ids that hit the full table. Now and
	// then the clock jumps to a random value, which usually restarts every window.
	task automatic send_mixed_event(input int step_max);
		int pick;
		logic [ID_W-1:0] cand;
		pick = $urandom_range(99);
		stamp_clock += $urandom_range(step_max);
		if ($urandom_range(199) == 0) begin
			stamp_clock = $urandom();
		end
		if (pick < 5) begin
			send_event(ID_W'($urandom_range(65535)), $urandom(), 1'b1);
		end else if (pick < 8) begin
			send_event('0, stamp_clock, 1'b0);
		end else if (pick < 15) begin
			do begin
				cand = ID_W'($urandom_range(65535));
			end while (cand == '0 || id_taken(cand, 16));
			send_event(cand, stamp_clock, 1'b0);
		end else begin
			send_event(known_ids[4'($urandom_range(15))], stamp_clock, 1'b0);
		end
	endtask

	task automatic run_phase(input int n, input int step_max);
		repeat (n) send_mixed_event(step_max);
		drain_results();
	endtask

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("event_rate_aggregation_filter_core: mismatch");
		$finish;
	end

	initial begin
		logic [ID_W-1:0] cand;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		evt.valid = 1'b0;
		evt.event_id = '0;
		evt.now_ms = '0;
		evt.bypass = 1'b0;
		result_hold = 1'b0;
		send_idle_pct = 31;
		recv_idle_pct = 68;
		stamp_clock = 32'hFFFF_FC00;

		known_ids[0] = 16'h0001;
		known_ids[1] = 16'hFFFF;
		for (int i = 2; i < 16; i++) begin
			do begin
				cand = ID_W'($urandom_range(65535));
			end while (cand == '0 || id_taken(cand, i));
			known_ids[i] = cand;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. First a few words under the reset register values: bypass
		// ahead of the reserved id, the reserved id itself, and a first claim.
		send_event('0, '0, 1'b1);
		send_event('0, 32'd100, 1'b0);
		send_event(known_ids[0], 32'd100, 1'b0);
		drain_results();

		// A short window, a threshold of two and one word in three sampled let a few
		// words walk one id through every verdict of its window.
		apply_settings(16'd5, 16'd2, 8'd3);
		send_event(known_ids[0], 32'd101, 1'b0);
		send_event(known_ids[0], 32'd102, 1'b0);
		send_event(known_ids[0], 32'd103, 1'b0);
		send_event(known_ids[0], 32'd104, 1'b0);
		// Elapsed time equal to the window still belongs to the window.
		send_event(known_ids[0], 32'd105, 1'b0);
		// One more millisecond restarts it.
		send_event(known_ids[0], 32'd106, 1'b0);
		// A time stamp behind the window start wraps to a huge elapsed time.
		send_event(known_ids[0], 32'd50, 1'b0);
		// Window start at the top of the time range, next word across the wrap.
		send_event(known_ids[1], 32'hFFFF_FFFF, 1'b0);
		send_event(known_ids[1], 32'h0000_0000, 1'b0);
		// Fill the rest of the table, then an unknown id finds it full.
		for (int i = 2; i < 16; i++) begin
			send_event(known_ids[i], 32'd7, 1'b0);
		end
		do begin
			cand = ID_W'($urandom_range(65535));
		end while (cand == '0 || id_taken(cand, 16));
		send_event(cand, 32'd8, 1'b0);
		send_event(known_ids[0], 32'hFFFF_FFFF, 1'b1);
		drain_results();

		// Random part, sender idling less than the receiver. The split into two runs
		// makes the sender pause until every verdict has come back.
		apply_settings(16'd1000, 16'd10, 8'd8);
		run_phase(110, 20);
		run_phase(110, 20);

		// Zero-length window: only words in the same millisecond share a window. With
		// no free quota and one-in-one sampling every counted word is sampled.
		apply_settings(16'd0, 16'd0, 8'd1);
		run_phase(200, 2);

		// Receiver now idles less than the sender.
		send_idle_pct = 68;
		recv_idle_pct = 31;

		// Longest window and slow sampling let phases climb high; the next setting
		// shrinks the divisor below them.
		apply_settings(16'hFFFF, 16'd0, 8'd200);
		run_phase(220, 5);
		apply_settings(16'hFFFF, 16'd0, 8'd3);
		run_phase(200, 5);

		// A divisor of zero behaves like one.
		apply_settings(16'd50, 16'd3, 8'd0);
		run_phase(200, 3);

		// Neither side idles from here on.
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// The receiver holds off for a long stretch while the sender keeps offering
		// words, so the block fills and stops accepting.
		apply_settings(CNT_W'($urandom_range(2000)), CNT_W'($urandom_range(20)),
			SAMPLE_W'($urandom_range(255)));
		fork
			begin
				@(posedge clk);
				result_hold = 1'b1;
				repeat (400) @(posedge clk);
				result_hold = 1'b0;
			end
		join_none
		run_phase(220, 15);

		apply_settings(16'd300, 16'hFFFF, 8'hFF);
		run_phase(200, 10);

		apply_settings(CNT_W'($urandom_range(65535)), CNT_W'($urandom_range(40)),
			SAMPLE_W'($urandom_range(1, 16)));
		run_phase(240, 50);

		// With the largest threshold every word of one id at a fixed time stays under it.
		apply_settings(16'd0, 16'hFFFF, 8'd255);
		repeat (4) send_event(known_ids[2], 32'h1234_5678, 1'b0);
		drain_results();

		if (tracker.errors == 0) begin
			$display("event_rate_aggregation_filter_core: match");
		end else begin
			$display("event_rate_aggregation_filter_core: mismatch");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/erafl_pkg.sv
hw/rtl/erafl_if.sv
hw/rtl/erafl_datapath.sv
hw/rtl/erafl_ctrl.sv
hw/rtl/event_rate_aggregation_filter_core.sv
hw/rtl/erafl_checker.sv
test/tb_top.sv
